// File: hdl/round_robin_thread_scheduler_core_assert.svh
// Assertion macros for the scheduler checker.
`ifndef ROUND_ROBIN_THREAD_SCHEDULER_CORE_ASSERT_SVH
`define ROUND_ROBIN_THREAD_SCHEDULER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RRTS_ASSERT_IMP(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("round robin scheduler check failed");

// Next-cycle implication, disabled while reset is asserted.
`define RRTS_ASSERT_NXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("round robin scheduler check failed");

`endif

// File: hdl/rrts_pkg.sv
// Types and codes shared by the round-robin thread scheduler modules.
package rrts_pkg;

    // Per-slot thread state.
    typedef enum logic [1:0] {
        ST_UNUSED,
        ST_RUNNABLE,
        ST_RUNNING,
        ST_FINISHED
    } slot_state_t;

    // Event kinds carried on the input channel.
    typedef enum logic [1:0] {
        EV_CREATE,
        EV_YIELD,
        EV_EXIT,
        EV_JOIN
    } event_kind_t;

    // Result status codes.
    typedef enum logic [1:0] {
        RES_OK,
        RES_FULL,
        RES_BAD_SLOT,
        RES_NOT_DONE
    } result_status_t;

    // Contents of one slot cell, handed from cell to cell around the ring.
    typedef struct packed {
        slot_state_t state;
        logic [31:0] entry;
        logic [31:0] argument;
    } slot_t;

endpackage

// File: hdl/rrts_cell.sv
// One slot cell of the scheduler ring: holds a slot and passes it on when the ring shifts.
module rrts_cell #(
    parameter rrts_pkg::slot_state_t RESET_STATE = rrts_pkg::ST_UNUSED
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            shift_en,
    input  rrts_pkg::slot_t slot_in,
    output rrts_pkg::slot_t slot_out
);

    rrts_pkg::slot_state_t state_reg;
    logic [31:0]           entry_reg;
    logic [31:0]           argument_reg;

    // Slot state: reset to its home value, load from the neighbor on shift.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= RESET_STATE;
        end else if (shift_en) begin
            state_reg <= slot_in.state;
        end
    end

    // Stored words: no reset, only meaningful once written by a create.
    always_ff @(posedge aclk) begin
        if (shift_en) begin
            entry_reg    <= slot_in.entry;
            argument_reg <= slot_in.argument;
        end
    end

    assign slot_out.state    = state_reg;
    assign slot_out.entry    = entry_reg;
    assign slot_out.argument = argument_reg;

endmodule

// File: hdl/rrts_ctrl.sv
// Scheduler sequencer: watches the ring head, edits slots as they wrap, builds results.
module rrts_ctrl #(
    parameter int THREAD_SLOTS = 8
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic [1:0]      s_kind,
    input  logic [2:0]      s_target_slot,
    input  logic [31:0]     s_start_entry,
    input  logic [31:0]     s_start_argument,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [1:0]      m_status,
    output logic [2:0]      m_slot_id,
    output logic            m_switched,
    output logic [31:0]     m_run_entry,
    output logic [31:0]     m_run_argument,
    input  rrts_pkg::slot_t head_i,
    output rrts_pkg::slot_t wrap_o,
    output logic            shift_o
);

    localparam int SW = $clog2(THREAD_SLOTS);
    localparam int CW = (SW > 3) ? SW : 3;
    localparam logic [SW-1:0] LAST = SW'(THREAD_SLOTS - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_APPLY,
        S_FINISH
    } state_t;

    state_t                   state_reg, state_next;
    logic [SW-1:0]            step_reg, step_next;
    rrts_pkg::event_kind_t    kind_reg, kind_next;
    logic [2:0]               target_reg, target_next;
    logic [31:0]              entry_in_reg, entry_in_next;
    logic [31:0]              arg_in_reg, arg_in_next;
    logic [SW-1:0]            cur_reg, cur_next;
    logic                     join_ok_reg, join_ok_next;
    logic                     hit_reg, hit_next;
    logic                     hi_found_reg, hi_found_next;
    logic [SW-1:0]            hi_reg, hi_next;
    logic                     lo_found_reg, lo_found_next;
    logic [SW-1:0]            lo_reg, lo_next;
    rrts_pkg::result_status_t res_status_reg, res_status_next;
    logic [2:0]               res_slot_reg, res_slot_next;
    logic                     res_sw_reg, res_sw_next;
    logic [31:0]              res_entry_reg, res_entry_next;
    logic [31:0]              res_arg_reg, res_arg_next;
    logic                     m_valid_reg, m_valid_next;
    rrts_pkg::result_status_t m_status_reg, m_status_next;
    logic [2:0]               m_slot_reg, m_slot_next;
    logic                     m_sw_reg, m_sw_next;
    logic [31:0]              m_entry_reg, m_entry_next;
    logic [31:0]              m_arg_reg, m_arg_next;

    rrts_pkg::event_kind_t in_kind;
    logic                  found;
    logic [SW-1:0]         nxt;
    logic                  runnable;
    logic [2:0]            cur_slot3;
    logic [2:0]            step_slot3;
    logic [2:0]            nxt_slot3;

    assign in_kind    = rrts_pkg::event_kind_t'(s_kind);
    assign found      = hi_found_reg | lo_found_reg;
    assign nxt        = hi_found_reg ? hi_reg : lo_reg;
    assign cur_slot3  = 3'(CW'(cur_reg));
    assign step_slot3 = 3'(CW'(step_reg));
    assign nxt_slot3  = 3'(CW'(nxt));
    // Slot at the head counts as runnable if its state is runnable; an exiting slot is already finished.
    assign runnable   = (head_i.state == rrts_pkg::ST_RUNNABLE) &&
                        !((kind_reg == rrts_pkg::EV_EXIT) && (step_reg == cur_reg));

    assign s_ready        = (state_reg == S_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_slot_id      = m_slot_reg;
    assign m_switched     = m_sw_reg;
    assign m_run_entry    = m_entry_reg;
    assign m_run_argument = m_arg_reg;

    // Next-state logic of the sequencer.
    always_comb begin
        state_next      = state_reg;
        step_next       = step_reg;
        kind_next       = kind_reg;
        target_next     = target_reg;
        entry_in_next   = entry_in_reg;
        arg_in_next     = arg_in_reg;
        cur_next        = cur_reg;
        join_ok_next    = join_ok_reg;
        hit_next        = hit_reg;
        hi_found_next   = hi_found_reg;
        hi_next         = hi_reg;
        lo_found_next   = lo_found_reg;
        lo_next         = lo_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_sw_next     = res_sw_reg;
        res_entry_next  = res_entry_reg;
        res_arg_next    = res_arg_reg;
        m_valid_next    = m_valid_reg;
        m_status_next   = m_status_reg;
        m_slot_next     = m_slot_reg;
        m_sw_next       = m_sw_reg;
        m_entry_next    = m_entry_reg;
        m_arg_next      = m_arg_reg;
        wrap_o          = head_i;
        shift_o         = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    kind_next     = in_kind;
                    target_next   = s_target_slot;
                    entry_in_next = s_start_entry;
                    arg_in_next   = s_start_argument;
                    step_next     = '0;
                    hit_next      = 1'b0;
                    hi_found_next = 1'b0;
                    lo_found_next = 1'b0;
                    join_ok_next  = (s_target_slot != 3'd0) &&
                                    (32'(s_target_slot) < 32'(THREAD_SLOTS)) &&
                                    (CW'(s_target_slot) != CW'(cur_reg));
                    res_sw_next    = 1'b0;
                    res_entry_next = '0;
                    res_arg_next   = '0;
                    // Result defaults, overridden during the scan and apply laps.
                    case (in_kind)
                        rrts_pkg::EV_CREATE: begin
                            res_status_next = rrts_pkg::RES_FULL;
                            res_slot_next   = 3'd0;
                        end
                        rrts_pkg::EV_JOIN: begin
                            res_status_next = rrts_pkg::RES_BAD_SLOT;
                            res_slot_next   = s_target_slot;
                        end
                        default: begin
                            res_status_next = rrts_pkg::RES_OK;
                            res_slot_next   = cur_slot3;
                        end
                    endcase
                    state_next = S_SCAN;
                end
            end

            S_SCAN: begin
                shift_o = 1'b1;
                case (kind_reg)
                    rrts_pkg::EV_CREATE: begin
                        // Lowest unused slot above zero takes the new thread.
                        if (!hit_reg && (step_reg != '0) &&
                            (head_i.state == rrts_pkg::ST_UNUSED)) begin
                            wrap_o.state    = rrts_pkg::ST_RUNNABLE;
                            wrap_o.entry    = entry_in_reg;
                            wrap_o.argument = arg_in_reg;
                            hit_next        = 1'b1;
                            res_status_next = rrts_pkg::RES_OK;
                            res_slot_next   = step_slot3;
                        end
                    end
                    rrts_pkg::EV_JOIN: begin
                        if (join_ok_reg && (CW'(step_reg) == CW'(target_reg))) begin
                            case (head_i.state)
                                rrts_pkg::ST_FINISHED: begin
                                    wrap_o.state    = rrts_pkg::ST_UNUSED;
                                    wrap_o.entry    = '0;
                                    wrap_o.argument = '0;
                                    res_status_next = rrts_pkg::RES_OK;
                                end
                                rrts_pkg::ST_UNUSED: begin
                                    res_status_next = rrts_pkg::RES_BAD_SLOT;
                                end
                                default: begin
                                    res_status_next = rrts_pkg::RES_NOT_DONE;
                                end
                            endcase
                        end
                    end
                    rrts_pkg::EV_YIELD, rrts_pkg::EV_EXIT: begin
                        // First runnable above current, else first at or below it.
                        if (runnable) begin
                            if ((step_reg > cur_reg) && !hi_found_reg) begin
                                hi_found_next = 1'b1;
                                hi_next       = step_reg;
                            end
                            if ((step_reg <= cur_reg) && !lo_found_reg) begin
                                lo_found_next = 1'b1;
                                lo_next       = step_reg;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
                if (step_reg == LAST) begin
                    step_next  = '0;
                    state_next = ((kind_reg == rrts_pkg::EV_YIELD) ||
                                  (kind_reg == rrts_pkg::EV_EXIT)) ? S_APPLY : S_FINISH;
                end else begin
                    step_next = step_reg + SW'(1);
                end
            end

            S_APPLY: begin
                // Second lap: switch to the chosen slot, demote or finish the old one.
                shift_o = 1'b1;
                if (found && (step_reg == nxt)) begin
                    wrap_o.state   = rrts_pkg::ST_RUNNING;
                    res_slot_next  = nxt_slot3;
                    res_sw_next    = (nxt != cur_reg);
                    res_entry_next = head_i.entry;
                    res_arg_next   = head_i.argument;
                end else if ((step_reg == cur_reg) && (kind_reg == rrts_pkg::EV_EXIT)) begin
                    wrap_o.state = rrts_pkg::ST_FINISHED;
                end else if ((step_reg == cur_reg) && found &&
                             (head_i.state == rrts_pkg::ST_RUNNING)) begin
                    wrap_o.state = rrts_pkg::ST_RUNNABLE;
                end
                if (step_reg == LAST) begin
                    step_next  = '0;
                    state_next = S_FINISH;
                    if (found) begin
                        cur_next = nxt;
                    end
                end else begin
                    step_next = step_reg + SW'(1);
                end
            end

            S_FINISH: begin
                // Hand the result to the output register once it is free.
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_slot_next   = res_slot_reg;
                    m_sw_next     = res_sw_reg;
                    m_entry_next  = res_entry_reg;
                    m_arg_next    = res_arg_reg;
                    state_next    = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            step_reg     <= '0;
            cur_reg      <= '0;
            m_valid_reg  <= 1'b0;
            hit_reg      <= 1'b0;
            hi_found_reg <= 1'b0;
            lo_found_reg <= 1'b0;
            join_ok_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            step_reg       <= step_next;
            cur_reg        <= cur_next;
            m_valid_reg    <= m_valid_next;
            hit_reg        <= hit_next;
            hi_found_reg   <= hi_found_next;
            lo_found_reg   <= lo_found_next;
            join_ok_reg    <= join_ok_next;
            kind_reg       <= kind_next;
            target_reg     <= target_next;
            entry_in_reg   <= entry_in_next;
            arg_in_reg     <= arg_in_next;
            hi_reg         <= hi_next;
            lo_reg         <= lo_next;
            res_status_reg <= res_status_next;
            res_slot_reg   <= res_slot_next;
            res_sw_reg     <= res_sw_next;
            res_entry_reg  <= res_entry_next;
            res_arg_reg    <= res_arg_next;
            m_status_reg   <= m_status_next;
            m_slot_reg     <= m_slot_next;
            m_sw_reg       <= m_sw_next;
            m_entry_reg    <= m_entry_next;
            m_arg_reg      <= m_arg_next;
        end
    end

endmodule

// File: hdl/round_robin_thread_scheduler_core.sv
// Round-robin thread scheduler: a ring of THREAD_SLOTS slot cells and a sequencer at its head.
// Create and join take one lap of the ring, then the result is registered.
// Yield and exit take a search lap and an update lap, then the result is registered.
// One event at a time; the next is accepted the cycle after the result is registered, and a
// result waits to be registered while the output still holds one that is not yet taken.
// Synchronous active-low reset: slot 0 running and current, all other slots unused.
module round_robin_thread_scheduler_core #(
    parameter int THREAD_SLOTS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_kind,
    input  logic [2:0]  s_target_slot,
    input  logic [31:0] s_start_entry,
    input  logic [31:0] s_start_argument,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [2:0]  m_slot_id,
    output logic        m_switched,
    output logic [31:0] m_run_entry,
    output logic [31:0] m_run_argument
);

    rrts_pkg::slot_t ring [THREAD_SLOTS];
    rrts_pkg::slot_t wrap;
    logic            shift;

    // Ring of slot cells; the head wraps to the tail through the sequencer.
    for (genvar p = 0; p < THREAD_SLOTS; p++) begin : g_cell
        rrts_cell #(
            .RESET_STATE(rrts_pkg::slot_state_t'((p == 0) ? rrts_pkg::ST_RUNNING
                                                           : rrts_pkg::ST_UNUSED))
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .shift_en(shift),
            .slot_in ((p == THREAD_SLOTS - 1) ? wrap : ring[(p + 1) % THREAD_SLOTS]),
            .slot_out(ring[p])
        );
    end

    rrts_ctrl #(
        .THREAD_SLOTS(THREAD_SLOTS)
    ) u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_kind          (s_kind),
        .s_target_slot   (s_target_slot),
        .s_start_entry   (s_start_entry),
        .s_start_argument(s_start_argument),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_slot_id       (m_slot_id),
        .m_switched      (m_switched),
        .m_run_entry     (m_run_entry),
        .m_run_argument  (m_run_argument),
        .head_i          (ring[0]),
        .wrap_o          (wrap),
        .shift_o         (shift)
    );

endmodule

// File: hdl/rrts_checker.sv
// Port-level checker for the scheduler, bound to the top level.
`include "round_robin_thread_scheduler_core_assert.svh"

module rrts_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic [1:0]  s_kind,
    input logic [2:0]  s_target_slot,
    input logic [31:0] s_start_entry,
    input logic [31:0] s_start_argument,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_status,
    input logic [2:0]  m_slot_id,
    input logic        m_switched,
    input logic [31:0] m_run_entry,
    input logic [31:0] m_run_argument
);

    // One event in flight: an accepted transaction closes the input side.
    `RRTS_ASSERT_NXT(a_one_in_flight, aclk, aresetn, s_valid && s_ready, !s_ready)

    // A full table never names a slot or switches.
    `RRTS_ASSERT_IMP(a_full_result, aclk, aresetn, m_valid && (m_status == rrts_pkg::RES_FULL), (m_slot_id == 3'd0) && !m_switched)

    // A thread switch only comes with an ok status.
    `RRTS_ASSERT_IMP(a_switch_ok, aclk, aresetn, m_valid && m_switched, m_status == rrts_pkg::RES_OK)

    // A rejected join carries no run words.
    `RRTS_ASSERT_IMP(a_bad_slot_clean, aclk, aresetn, m_valid && (m_status == rrts_pkg::RES_BAD_SLOT), !m_switched && (m_run_entry == 32'd0) && (m_run_argument == 32'd0))

    // A stalled result holds.
    `RRTS_ASSERT_NXT(a_result_holds, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_status) && $stable(m_slot_id) && $stable(m_run_entry))

endmodule

bind round_robin_thread_scheduler_core rrts_checker u_rrts_checker (.*);

// File: bench/tb_round_robin_thread_scheduler_core.sv
// Self-checking bench for the round-robin thread scheduler core: directed and random events against a predictor.
module tb_round_robin_thread_scheduler_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLOT         = 8;
    localparam int RANDOM_EVENTS = 1180;
    localparam int MAX_GAP       = 12;
    localparam int LONG_HOLD     = 400;
    localparam int LONG_HOLD_AT  = 300;
    localparam int STALL_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 2 * NSLOT + 24;

    // Scheduler view kept by the bench
    typedef struct packed {
        rrts_pkg::slot_state_t [NSLOT-1:0] st;
        logic [2:0]                        cur;
        logic [NSLOT-1:0][31:0]            entry;
        logic [NSLOT-1:0][31:0]            arg;
    } sched_state_t;

    typedef struct packed {
        rrts_pkg::event_kind_t kind;
        logic [2:0]            target;
        logic [31:0]           entry;
        logic [31:0]           arg;
        logic [3:0]            gap;
    } sched_event_t;

    typedef struct packed {
        rrts_pkg::result_status_t status;
        logic [2:0]               slot;
        logic                     switched;
        logic [31:0]              run_entry;
        logic [31:0]              run_arg;
    } sched_result_t;

    logic        aclk;
    logic        aresetn          = 1'b0;
    logic        s_valid          = 1'b0;
    logic        s_ready;
    logic [1:0]  s_kind           = '0;
    logic [2:0]  s_target_slot    = '0;
    logic [31:0] s_start_entry    = '0;
    logic [31:0] s_start_argument = '0;
    logic        m_valid;
    logic        m_ready          = 1'b0;
    logic [1:0]  m_status;
    logic [2:0]  m_slot_id;
    logic        m_switched;
    logic [31:0] m_run_entry;
    logic [31:0] m_run_argument;

    sched_event_t  pending_q[$];
    sched_result_t predicted_q[$];
    sched_state_t  plan;
    sched_state_t  model;

    int  total_events    = 0;
    int  accepted_count  = 0;
    int  mismatch_count  = 0;
    int  idle_cycles     = 0;
    bit  no_idle         = 1'b0;
    bit  in_taken        = 1'b0;
    bit  out_taken       = 1'b0;

    // Coverage tallies for the summary
    int  kind_count[4];
    int  full_count      = 0;
    int  switch_count    = 0;
    int  halt_count      = 0;
    int  reap_count      = 0;
    int  bad_join_count  = 0;
    int  live_join_count = 0;

    round_robin_thread_scheduler_core #(
        .THREAD_SLOTS(NSLOT)
    ) uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_kind           (s_kind),
        .s_target_slot    (s_target_slot),
        .s_start_entry    (s_start_entry),
        .s_start_argument (s_start_argument),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_slot_id        (m_slot_id),
        .m_switched       (m_switched),
        .m_run_entry      (m_run_entry),
        .m_run_argument   (m_run_argument)
    );

    // State right after reset: slot 0 running and current
    function automatic sched_state_t idle_scheduler();
        sched_state_t s;
        s = '0;
        for (int i = 0; i < NSLOT; i++) s.st[i] = rrts_pkg::ST_UNUSED;
        s.st[0] = rrts_pkg::ST_RUNNING;
        return s;
    endfunction

    // Applies one event to a scheduler view and returns the result it produces
    function automatic sched_result_t apply_event(inout sched_state_t s, input sched_event_t ev);
        sched_result_t r;
        int            i;
        int            cand;
        int            pick;
        bit            found;
        r     = '0;
        found = 1'b0;
        pick  = 0;
        case (ev.kind)
            rrts_pkg::EV_CREATE: begin
                r.status = rrts_pkg::RES_FULL;
                for (i = 1; i < NSLOT; i++) begin
                    if (!found && s.st[i] == rrts_pkg::ST_UNUSED) begin
                        found      = 1'b1;
                        s.st[i]    = rrts_pkg::ST_RUNNABLE;
                        s.entry[i] = ev.entry;
                        s.arg[i]   = ev.arg;
                        r.status   = rrts_pkg::RES_OK;
                        r.slot     = i[2:0];
                    end
                end
            end
            rrts_pkg::EV_YIELD, rrts_pkg::EV_EXIT: begin
                if (ev.kind == rrts_pkg::EV_EXIT) s.st[s.cur] = rrts_pkg::ST_FINISHED;
                r.status = rrts_pkg::RES_OK;
                r.slot   = s.cur;
                // round-robin search starting just after the current slot
                for (i = 1; i <= NSLOT; i++) begin
                    cand = (int'(s.cur) + i) % NSLOT;
                    if (!found && s.st[cand] == rrts_pkg::ST_RUNNABLE) begin
                        found = 1'b1;
                        pick  = cand;
                    end
                end
                if (found) begin
                    if (s.st[s.cur] == rrts_pkg::ST_RUNNING) s.st[s.cur] = rrts_pkg::ST_RUNNABLE;
                    s.st[pick]  = rrts_pkg::ST_RUNNING;
                    r.switched  = (pick != int'(s.cur));
                    s.cur       = pick[2:0];
                    r.slot      = pick[2:0];
                    r.run_entry = s.entry[pick];
                    r.run_arg   = s.arg[pick];
                end
            end
            default: begin
                r.slot = ev.target;
                if (ev.target == 0 || ev.target == s.cur ||
                    s.st[ev.target] == rrts_pkg::ST_UNUSED) begin
                    r.status = rrts_pkg::RES_BAD_SLOT;
                end else if (s.st[ev.target] == rrts_pkg::ST_FINISHED) begin
                    s.st[ev.target]    = rrts_pkg::ST_UNUSED;
                    s.entry[ev.target] = '0;
                    s.arg[ev.target]   = '0;
                    r.status           = rrts_pkg::RES_OK;
                end else begin
                    r.status = rrts_pkg::RES_NOT_DONE;
                end
            end
        endcase
        return r;
    endfunction

    // Queues one event and advances the planning view so later choices see its effect
    task automatic queue_event(input rrts_pkg::event_kind_t kind, input logic [2:0] target,
                               input logic [31:0] entry, input logic [31:0] arg);
        sched_event_t ev;
        ev.kind    = kind;
        ev.target  = target;
        ev.entry   = entry;
        ev.arg     = arg;
        ev.gap     = no_idle ? 4'd0 : 4'($urandom_range(0, MAX_GAP));
        void'(apply_event(plan, ev));
        pending_q.push_back(ev);
        total_events++;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch: expected %h, actual %h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // Clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Driver: presents queued events after each one's idle gap
    sched_event_t cur_item;
    int           wait_cnt = 0;

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !in_taken) begin
            // hold the transaction until it is taken
        end else if (pending_q.size() > 0 && wait_cnt < int'(pending_q[0].gap)) begin
            s_valid <= 1'b0;
            wait_cnt++;
        end else if (pending_q.size() > 0) begin
            cur_item         = pending_q.pop_front();
            wait_cnt         = 0;
            s_kind           <= cur_item.kind;
            s_target_slot    <= cur_item.target;
            s_start_entry    <= cur_item.entry;
            s_start_argument <= cur_item.arg;
            s_valid          <= 1'b1;
        end else begin
            s_valid <= 1'b0;
        end
    end

    // Receiver: random back-pressure, calm stretches, and one long hold
    int stall_left   = 0;
    int results_seen = 0;
    bit rx_calm      = 1'b0;

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (out_taken) begin
                results_seen++;
                if (results_seen % 50 == 0) rx_calm = ($urandom_range(0, 3) == 0);
                if (results_seen == LONG_HOLD_AT) stall_left = LONG_HOLD;
                else stall_left = rx_calm ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Monitor: predicts on each accepted event, checks each accepted result
    always @(posedge aclk) begin
        bit            in_fire;
        bit            out_fire;
        sched_event_t  ev;
        sched_result_t want;
        sched_result_t got;
        in_fire   = aresetn && s_valid && s_ready;
        out_fire  = aresetn && m_valid && m_ready;
        in_taken  <= in_fire;
        out_taken <= out_fire;
        idle_cycles <= (in_fire || out_fire || !aresetn) ? 0 : idle_cycles + 1;

        if (in_fire) begin
            ev.kind   = rrts_pkg::event_kind_t'(s_kind);
            ev.target = s_target_slot;
            ev.entry  = s_start_entry;
            ev.arg    = s_start_argument;
            ev.gap    = '0;
            want      = apply_event(model, ev);
            predicted_q.push_back(want);
            accepted_count++;
            kind_count[s_kind]++;
            if (want.switched) switch_count++;
            case (ev.kind)
                rrts_pkg::EV_CREATE: if (want.status == rrts_pkg::RES_FULL) full_count++;
                rrts_pkg::EV_EXIT:   if (!want.switched) halt_count++;
                rrts_pkg::EV_JOIN: begin
                    if (want.status == rrts_pkg::RES_OK) reap_count++;
                    else if (want.status == rrts_pkg::RES_BAD_SLOT) bad_join_count++;
                    else live_join_count++;
                end
                default: ;
            endcase
        end

        if (out_fire) begin
            got.status    = rrts_pkg::result_status_t'(m_status);
            got.slot      = m_slot_id;
            got.switched  = m_switched;
            got.run_entry = m_run_entry;
            got.run_arg   = m_run_argument;
            if (predicted_q.size() == 0) begin
                $display("%0t ns: result with no event pending: status %0d slot %0d",
                         $time, m_status, m_slot_id);
                mismatch_count++;
            end else begin
                want = predicted_q.pop_front();
                check_field("status", 32'(want.status), 32'(got.status));
                check_field("slot_id", 32'(want.slot), 32'(got.slot));
                check_field("switched", 32'(want.switched), 32'(got.switched));
                check_field("run_entry", want.run_entry, got.run_entry);
                check_field("run_argument", want.run_arg, got.run_arg);
            end
        end
    end

    // Watchdog on cycles without any transaction
    initial begin
        @(negedge aclk);
        while (idle_cycles < STALL_LIMIT) @(negedge aclk);
        $display("%0t ns: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    // Stimulus and end of run
    initial begin
        int                    n;
        int                    j;
        int                    mode;
        int                    roll;
        int                    off;
        int                    c_lim;
        int                    y_lim;
        int                    x_lim;
        rrts_pkg::event_kind_t kind;
        logic [2:0]            tgt;
        plan  = idle_scheduler();
        model = idle_scheduler();
        foreach (kind_count[k]) kind_count[k] = 0;

        // Directed: empty table, rejected joins, extreme words, slot 0 exiting,
        // full table, reaping and slot reuse
        queue_event(rrts_pkg::EV_YIELD,  3'd0, 32'h0, 32'h0);
        queue_event(rrts_pkg::EV_JOIN,   3'd0, 32'h0, 32'h0);
        queue_event(rrts_pkg::EV_JOIN,   3'd5, 32'h0, 32'h0);
        queue_event(rrts_pkg::EV_CREATE, 3'd0, 32'h0000_0000, 32'h0000_0000);
        queue_event(rrts_pkg::EV_JOIN,   3'd1, 32'h0, 32'h0);
        queue_event(rrts_pkg::EV_CREATE, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_event(rrts_pkg::EV_EXIT,   3'd0, 32'h0, 32'h0);
        queue_event(rrts_pkg::EV_JOIN,   3'd1, 32'h0, 32'h0);
        queue_event(rrts_pkg::EV_YIELD,  3'd0, 32'h0, 32'h0);
        queue_event(rrts_pkg::EV_JOIN,   3'd1, 32'h0, 32'h0);
        queue_event(rrts_pkg::EV_CREATE, 3'd0, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
        queue_event(rrts_pkg::EV_CREATE, 3'd0, 32'h5A5A_5A5A, 32'hA5A5_A5A5);
        queue_event(rrts_pkg::EV_CREATE, 3'd0, 32'h8000_0001, 32'h7FFF_FFFE);
        queue_event(rrts_pkg::EV_CREATE, 3'd0, 32'h7FFF_FFFE, 32'h8000_0001);
        queue_event(rrts_pkg::EV_CREATE, 3'd0, 32'h1234_5678, 32'h8765_4321);
        queue_event(rrts_pkg::EV_CREATE, 3'd0, 32'hDEAD_BEEF, 32'hCAFE_F00D);
        queue_event(rrts_pkg::EV_JOIN,   3'd7, 32'h0, 32'h0);
        queue_event(rrts_pkg::EV_EXIT,   3'd0, 32'h0, 32'h0);
        queue_event(rrts_pkg::EV_JOIN,   3'd2, 32'h0, 32'h0);
        queue_event(rrts_pkg::EV_CREATE, 3'd0, 32'h0F0F_0F0F, 32'hF0F0_F0F0);

        // Random: phases that fill, drain or mix the table
        mode  = 0;
        c_lim = 30;
        y_lim = 60;
        x_lim = 75;
        for (n = 0; n < RANDOM_EVENTS; n++) begin
            if (n % 100 == 0) begin
                mode    = $urandom_range(0, 2);
                no_idle = ($urandom_range(0, 3) == 0);
                case (mode)
                    0:       begin c_lim = 30; y_lim = 60; x_lim = 75; end
                    1:       begin c_lim = 55; y_lim = 80; x_lim = 85; end
                    default: begin c_lim = 10; y_lim = 30; x_lim = 65; end
                endcase
            end
            roll = $urandom_range(0, 99);
            if (roll < c_lim)      kind = rrts_pkg::EV_CREATE;
            else if (roll < y_lim) kind = rrts_pkg::EV_YIELD;
            else if (roll < x_lim) kind = rrts_pkg::EV_EXIT;
            else                   kind = rrts_pkg::EV_JOIN;
            tgt = 3'($urandom_range(0, 7));
            // joins mostly aim at a finished thread so reaping happens often
            if (kind == rrts_pkg::EV_JOIN && $urandom_range(0, 9) < 7) begin
                off = $urandom_range(0, NSLOT - 1);
                for (j = 0; j < NSLOT; j++) begin
                    if ((off + j) % NSLOT != 0 &&
                        plan.st[(off + j) % NSLOT] == rrts_pkg::ST_FINISHED)
                        tgt = 3'((off + j) % NSLOT);
                end
            end
            queue_event(kind, tgt, $urandom, $urandom);
        end

        // Reset
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        // Wait for every event to be taken and answered, then let the block settle
        while (!(accepted_count == total_events && predicted_q.size() == 0)) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $write("covered %0d events: %0d creates (%0d on a full table), %0d yields, ",
               accepted_count, kind_count[rrts_pkg::EV_CREATE], full_count,
               kind_count[rrts_pkg::EV_YIELD]);
        $display("%0d exits (%0d with nothing left to run), %0d joins",
                 kind_count[rrts_pkg::EV_EXIT], halt_count, kind_count[rrts_pkg::EV_JOIN]);
        $write("  %0d thread switches, %0d threads reaped, ", switch_count, reap_count);
        $display("%0d joins rejected, %0d joins of live threads",
                 bad_join_count, live_join_count);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
